// ===== rtl/wfm_pkg.sv =====
// wfm_pkg: shared types and constants of the wildcard flow match block
// word layouts, wildcard bit positions, request codes and sequencer states
// no dependencies
package wfm_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned WORDS_PER_ENTRY = 5;
    localparam int unsigned KEY_WORDS       = 4;
    localparam int unsigned WC_W            = 22;
    localparam int unsigned IDX_W           = 6;
    localparam int unsigned SEL_W           = 3;

    localparam logic [WC_W-1:0] WC_FULL       = 22'h3F_FFFF;
    localparam logic [15:0]     TPID_VLAN     = 16'h8100;
    localparam logic [15:0]     TCI_VID_MASK  = 16'h0FFF;
    localparam logic [15:0]     TCI_PCP_MASK  = 16'hE000;
    localparam int unsigned     TCI_PCP_SHIFT = 13;

    // wildcard bit positions
    localparam int unsigned WB_IN_PORT     = 0;
    localparam int unsigned WB_DL_VLAN     = 1;
    localparam int unsigned WB_DL_SRC      = 2;
    localparam int unsigned WB_DL_DST      = 3;
    localparam int unsigned WB_DL_TYPE     = 4;
    localparam int unsigned WB_NW_PROTO    = 5;
    localparam int unsigned WB_TP_SRC      = 6;
    localparam int unsigned WB_TP_DST      = 7;
    localparam int unsigned WB_NW_SRC_ALL  = 13;
    localparam int unsigned WB_NW_DST_ALL  = 19;
    localparam int unsigned WB_DL_VLAN_PCP = 20;

    // word indexes
    localparam int unsigned W_PORT_DST = 0;
    localparam int unsigned W_TYPE_SRC = 1;
    localparam int unsigned W_IP       = 2;
    localparam int unsigned W_L4_VLAN  = 3;
    localparam int unsigned W_WILD     = 4;

    // presence flags in word 3
    localparam int unsigned B_L3_PRESENT = 56;
    localparam int unsigned B_L4_PRESENT = 57;

    typedef logic [WORDS_PER_ENTRY-1:0][WORD_W-1:0] t_entry;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]       t_key;

    typedef enum logic [1:0] {
        REQ_ENTRY_WR = 2'd0,
        REQ_KEY_WR   = 2'd1,
        REQ_LOOKUP   = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

// ===== rtl/wfm_store.sv =====
// wfm_store: flow table storage, one memory per entry word, registered read
// after reset a clearing pass zeroes one row per cycle until every row is cleared
// depends on wfm_pkg
module wfm_store #(
    parameter int unsigned ROWS  = 64,
    parameter int unsigned ROW_W = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ROW_W-1:0]           i_wr_row,
    input  logic [wfm_pkg::SEL_W-1:0]  i_wr_word,
    input  logic [wfm_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ROW_W-1:0]           i_rd_row,
    output wfm_pkg::t_entry            o_rd_entry,
    output logic                       o_clr_busy
);

    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_clr_busy = r_clr_busy;

    genvar w;
    generate
        for (w = 0; w < wfm_pkg::WORDS_PER_ENTRY; w++) begin : g_word
            logic [wfm_pkg::WORD_W-1:0] r_mem [ROWS];
            logic [wfm_pkg::WORD_W-1:0] r_rd_word;

            always_ff @(posedge i_clk) begin
                if (r_clr_busy) begin
                    r_mem[r_clr_row] <= '0;
                end else if (i_wr_en && (i_wr_word == wfm_pkg::SEL_W'(w))) begin
                    r_mem[i_wr_row] <= i_wr_data;
                end
                if (i_rd_en) begin
                    r_rd_word <= r_mem[i_rd_row];
                end
            end

            assign o_rd_entry[w] = r_rd_word;
        end
    endgenerate

endmodule

// ===== rtl/wfm_cmp.sv =====
// wfm_cmp: compare unit, checks one table entry against the packet key
// layer 2, layer 3 and layer 4 checks with wildcard accumulation
// depends on wfm_pkg
module wfm_cmp (
    input  wfm_pkg::t_entry i_entry,
    input  wfm_pkg::t_key   i_key,
    output logic            o_match
);

    logic [wfm_pkg::WC_W-1:0] wc;
    logic [wfm_pkg::WC_W-1:0] wc_l2;
    logic [wfm_pkg::WC_W-1:0] wc_l3;
    logic [wfm_pkg::WC_W-1:0] wc_l4;
    logic [15:0]              ktype;
    logic [15:0]              ktci;
    logic [15:0]              etci;
    logic                     vlan_key;
    logic                     fail_l2;
    logic                     fail_l3;
    logic                     fail_l4;
    logic                     l3_present;
    logic                     l4_present;

    always_comb begin
        wc       = i_entry[wfm_pkg::W_WILD][wfm_pkg::WC_W-1:0];
        ktype    = i_key[wfm_pkg::W_TYPE_SRC][15:0];
        ktci     = i_key[wfm_pkg::W_L4_VLAN][47:32];
        etci     = i_entry[wfm_pkg::W_L4_VLAN][47:32];
        vlan_key = (ktype == wfm_pkg::TPID_VLAN);
        l3_present = i_key[wfm_pkg::W_L4_VLAN][wfm_pkg::B_L3_PRESENT];
        l4_present = i_key[wfm_pkg::W_L4_VLAN][wfm_pkg::B_L4_PRESENT];

        fail_l2 =
            (!wc[wfm_pkg::WB_IN_PORT] &&
             (i_entry[wfm_pkg::W_PORT_DST][15:0] != i_key[wfm_pkg::W_PORT_DST][15:0])) ||
            (vlan_key && !wc[wfm_pkg::WB_DL_VLAN] &&
             ((ktci & wfm_pkg::TCI_VID_MASK) != (etci & wfm_pkg::TCI_VID_MASK))) ||
            (vlan_key && !wc[wfm_pkg::WB_DL_VLAN_PCP] &&
             (((ktci & wfm_pkg::TCI_PCP_MASK) >> wfm_pkg::TCI_PCP_SHIFT) !=
              ((etci & wfm_pkg::TCI_PCP_MASK) >> wfm_pkg::TCI_PCP_SHIFT))) ||
            (!wc[wfm_pkg::WB_DL_DST] &&
             (i_entry[wfm_pkg::W_PORT_DST][63:16] != i_key[wfm_pkg::W_PORT_DST][63:16])) ||
            (!wc[wfm_pkg::WB_DL_SRC] &&
             (i_entry[wfm_pkg::W_TYPE_SRC][63:16] != i_key[wfm_pkg::W_TYPE_SRC][63:16])) ||
            (!wc[wfm_pkg::WB_DL_TYPE] &&
             (i_entry[wfm_pkg::W_TYPE_SRC][15:0] != ktype));

        wc_l2 = wc;
        wc_l2[wfm_pkg::WB_IN_PORT] = 1'b1;
        wc_l2[wfm_pkg::WB_DL_DST]  = 1'b1;
        wc_l2[wfm_pkg::WB_DL_SRC]  = 1'b1;
        wc_l2[wfm_pkg::WB_DL_TYPE] = 1'b1;
        if (vlan_key) begin
            wc_l2[wfm_pkg::WB_DL_VLAN]     = 1'b1;
            wc_l2[wfm_pkg::WB_DL_VLAN_PCP] = 1'b1;
        end

        fail_l3 =
            (!wc[wfm_pkg::WB_NW_PROTO] &&
             (i_entry[wfm_pkg::W_L4_VLAN][55:48] != i_key[wfm_pkg::W_L4_VLAN][55:48])) ||
            (!wc[wfm_pkg::WB_NW_DST_ALL] &&
             (i_entry[wfm_pkg::W_IP][63:32] != i_key[wfm_pkg::W_IP][63:32])) ||
            (!wc[wfm_pkg::WB_NW_SRC_ALL] &&
             (i_entry[wfm_pkg::W_IP][31:0] != i_key[wfm_pkg::W_IP][31:0]));

        wc_l3 = wc_l2;
        wc_l3[wfm_pkg::WB_NW_PROTO]   = 1'b1;
        wc_l3[wfm_pkg::WB_NW_DST_ALL] = 1'b1;
        wc_l3[wfm_pkg::WB_NW_SRC_ALL] = 1'b1;

        fail_l4 =
            (!wc[wfm_pkg::WB_TP_DST] &&
             (i_entry[wfm_pkg::W_L4_VLAN][31:16] != i_key[wfm_pkg::W_L4_VLAN][31:16])) ||
            (!wc[wfm_pkg::WB_TP_SRC] &&
             (i_entry[wfm_pkg::W_L4_VLAN][15:0] != i_key[wfm_pkg::W_L4_VLAN][15:0]));

        wc_l4 = wc_l3;
        wc_l4[wfm_pkg::WB_TP_DST] = 1'b1;
        wc_l4[wfm_pkg::WB_TP_SRC] = 1'b1;

        if (wc == '0) begin
            o_match = 1'b0;
        end else if (wc == wfm_pkg::WC_FULL) begin
            o_match = 1'b1;
        end else if (fail_l2) begin
            o_match = 1'b0;
        end else if (wc_l2 == wfm_pkg::WC_FULL) begin
            o_match = 1'b1;
        end else if (!l3_present || fail_l3) begin
            o_match = 1'b0;
        end else if (wc_l3 == wfm_pkg::WC_FULL) begin
            o_match = 1'b1;
        end else if (!l4_present || fail_l4) begin
            o_match = 1'b0;
        end else begin
            o_match = (wc_l4 == wfm_pkg::WC_FULL);
        end
    end

endmodule

// ===== rtl/wildcard_flow_match.sv =====
// wildcard_flow_match: top level, key store and scan sequencer
// instantiates wfm_store and wfm_cmp, depends on wfm_pkg
//
// usage
//   a command beat is taken when start is high and busy is low. entry-word
//   and key-word writes complete in that cycle, give no result and leave busy
//   low, so one write can follow in every cycle. writes to an entry beyond the
//   stored rows, an unused word select or request code 3 are dropped.
//   a lookup raises busy and scans the table in index order, one entry per
//   cycle through the shared compare unit; the table memory read is registered,
//   so each entry is read in the cycle before its compare. the first matching
//   entry ends the scan. o_done is strobed from a register after the compare
//   of the matching entry, or of the last stored entry on a miss. o_hit and
//   o_match_index are valid only with o_done, for one cycle; the receiver
//   cannot stall. only the first 64 entries can be written, later ones stay
//   empty and are not scanned. reset (synchronous, active low) zeroes the key
//   and starts a clearing pass that empties one row per cycle; busy stays high
//   until every stored row is cleared.
module wildcard_flow_match #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_req_type,
    input  logic [wfm_pkg::IDX_W-1:0]        i_entry_index,
    input  logic [wfm_pkg::SEL_W-1:0]        i_word_select,
    input  logic [wfm_pkg::WORD_W-1:0]       i_word_value,
    output logic                             o_done,
    output logic                             o_hit,
    output logic [wfm_pkg::IDX_W-1:0]        o_match_index
);

    localparam int unsigned MAX_ROWS = 1 << wfm_pkg::IDX_W;
    localparam int unsigned ROWS  = (TABLE_ENTRIES < MAX_ROWS) ? TABLE_ENTRIES : MAX_ROWS;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    wfm_pkg::t_state           r_state, n_state;
    wfm_pkg::t_key             r_key;
    logic [ROW_W-1:0]          r_addr, n_addr;
    logic                      r_issue, n_issue;
    logic                      r_rd_vld, n_rd_vld;
    logic [ROW_W-1:0]          r_rd_idx, n_rd_idx;
    logic                      r_done, n_done;
    logic                      r_hit, n_hit;
    logic [wfm_pkg::IDX_W-1:0] r_idx, n_idx;

    wfm_pkg::t_req   req;
    wfm_pkg::t_entry rd_entry;
    logic            accept;
    logic            entry_wr;
    logic            rd_en;
    logic            match;
    logic            clr_busy;

    assign req      = wfm_pkg::t_req'(i_req_type);
    assign busy     = (r_state != wfm_pkg::ST_IDLE) || clr_busy;
    assign accept   = start && !busy;
    assign entry_wr = accept && (req == wfm_pkg::REQ_ENTRY_WR) &&
                      ((ROWS == MAX_ROWS) ||
                       (i_entry_index < wfm_pkg::IDX_W'(ROWS))) &&
                      (i_word_select < wfm_pkg::SEL_W'(wfm_pkg::WORDS_PER_ENTRY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (accept && (req == wfm_pkg::REQ_KEY_WR) &&
                     (i_word_select < wfm_pkg::SEL_W'(wfm_pkg::KEY_WORDS))) begin
            r_key[i_word_select[1:0]] <= i_word_value;
        end
    end

    wfm_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (entry_wr),
        .i_wr_row   (i_entry_index[ROW_W-1:0]),
        .i_wr_word  (i_word_select),
        .i_wr_data  (i_word_value),
        .i_rd_en    (rd_en),
        .i_rd_row   (r_addr),
        .o_rd_entry (rd_entry),
        .o_clr_busy (clr_busy)
    );

    wfm_cmp u_cmp (
        .i_entry (rd_entry),
        .i_key   (r_key),
        .o_match (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wfm_pkg::ST_IDLE;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
            r_addr   <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
            r_hit    <= n_hit;
            r_idx    <= n_idx;
            r_addr   <= n_addr;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_issue  = r_issue;
        n_addr   = r_addr;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_done   = 1'b0;
        n_hit    = 1'b0;
        n_idx    = '0;
        rd_en    = 1'b0;
        case (r_state)
            wfm_pkg::ST_IDLE: begin
                if (accept && (req == wfm_pkg::REQ_LOOKUP)) begin
                    n_state = wfm_pkg::ST_SCAN;
                    n_issue = 1'b1;
                    n_addr  = '0;
                end
            end
            wfm_pkg::ST_SCAN: begin
                rd_en    = r_issue;
                n_rd_vld = r_issue;
                n_rd_idx = r_addr;
                if (r_issue) begin
                    n_addr  = r_addr + ROW_W'(1);
                    n_issue = (r_addr != LAST_ROW);
                end
                if (r_rd_vld && match) begin
                    n_state  = wfm_pkg::ST_IDLE;
                    n_issue  = 1'b0;
                    n_rd_vld = 1'b0;
                    n_done   = 1'b1;
                    n_hit    = 1'b1;
                    n_idx    = wfm_pkg::IDX_W'(r_rd_idx);
                end else if (r_rd_vld && (r_rd_idx == LAST_ROW)) begin
                    n_state  = wfm_pkg::ST_IDLE;
                    n_issue  = 1'b0;
                    n_rd_vld = 1'b0;
                    n_done   = 1'b1;
                end
            end
            default: begin
                n_state = wfm_pkg::ST_IDLE;
                n_issue = 1'b0;
            end
        endcase
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_match_index = r_idx;

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == wfm_pkg::ST_SCAN))
        else $error("result strobe without a preceding scan");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_match_index == '0))
        else $error("miss reported with nonzero index");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (req != wfm_pkg::REQ_LOOKUP)) |=> !busy)
        else $error("write beat made the block busy");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (req == wfm_pkg::REQ_LOOKUP)) |=> (busy && !o_done))
        else $error("lookup beat did not start a scan");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == wfm_pkg::ST_SCAN))
        else $error("table read data pending outside a scan");

endmodule
